// ----- design/atlf_pkg.sv -----
// ----------------------------------------------------------------------------
// atlf_pkg: shared types and constants of the at line framer
// character codes, tail patterns, status and action codes, write command
// ----------------------------------------------------------------------------
`default_nettype none

package atlf_pkg;

   // default bytes per bank
   localparam int BANK_BYTES_DEF = 64;

   // field widths fixed by the interface
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;
   localparam int TAIL_W   = 56;
   localparam int OK_W     = 32;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CMD  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RESP = 2'd2;

   // action codes
   localparam logic ACT_FEED = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // characters
   localparam logic [BYTE_W-1:0] CH_A    = 8'h41;
   localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_O    = 8'h4F;
   localparam logic [BYTE_W-1:0] CH_E    = 8'h45;
   localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

   // closing tails, newest byte lowest
   localparam logic [OK_W-1:0]   TAIL_OK    = 32'h4F4B_0D0A;
   localparam logic [TAIL_W-1:0] TAIL_ERROR = 56'h45_5252_4F52_0D0A;

   // minimum stored bytes before a tail may close a response
   localparam int OK_MIN    = 4;
   localparam int ERROR_MIN = 7;

   // bank write command from the parser
   typedef struct packed {
      logic set;    // store a byte at wr_pos
      logic clr;    // terminator: entry at clr_pos reads zero
      logic bank;   // bank both act on
   } atlf_wr_type;

endpackage

`default_nettype wire

// ----- design/at_line_framer.sv -----
// ----------------------------------------------------------------------------
// at_line_framer: at command and response framer
// frames received bytes into two alternating banks and reads back
// the bank that last completed
// ----------------------------------------------------------------------------
//
//  channel  direction  carries
//  -------  ---------  ------------------------------------------------------
//  req_     in         one item: feed a received byte or read a bank byte
//  rsp_     out        one item per request: status, completed bank, byte
//
//  one item per cycle sustained while rsp_ takes items; each item passes the
//  memory stage (bank memory access, registered read), then the output register
//  the bank store sits in one ram with a valid bit per entry; reset clears
//  the valid bits at once, so no clearing pass is needed after reset
//  a terminator write clears the entry's valid bit, so it reads zero
//  a stalled rsp_ side holds the output register; req_tready drops only
//  when both the memory stage and the output register are full
//
`default_nettype none

module at_line_framer #(
   parameter int BANK_BYTES = atlf_pkg::BANK_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] byte_in, [13:8] read_index
   input  wire logic        req_tuser,   // [0] action
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [1:0] status, [2] completed_bank,
                                         // [10:3] read_byte
);

   localparam int FILL_W = $clog2(BANK_BYTES);
   localparam int DEPTH  = 2 * BANK_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int BW     = atlf_pkg::BYTE_W;
   localparam int SW     = atlf_pkg::STATUS_W;
   localparam int OUT_W  = SW + 1 + BW;

   // request fields
   logic                      action;
   logic [BW-1:0]             byte_in;
   logic [atlf_pkg::INDEX_W-1:0] read_index;

   assign action     = req_tuser;
   assign byte_in    = req_tdata[BW-1:0];
   assign read_index = req_tdata[BW+atlf_pkg::INDEX_W-1:BW];

   // handshake and pipeline control
   logic accept;
   logic feed_en;
   logic read_en;
   logic s1_move;

   // parser interface
   atlf_pkg::atlf_wr_type     wr;
   logic [FILL_W-1:0]         wr_pos;
   logic [FILL_W-1:0]         clr_pos;
   logic [SW-1:0]             status;
   logic                      done_bank;

   // memory side
   logic [ADDR_W-1:0]         wr_addr;
   logic [ADDR_W-1:0]         clr_addr;
   logic [ADDR_W-1:0]         rd_addr;
   logic [FILL_W-1:0]         rd_pos;
   logic                      rd_in_bank;
   logic [BW-1:0]             rd_data;
   logic [DEPTH-1:0]          valid_ff, valid_in;

   // memory stage
   logic                      s1_valid_ff;
   logic [SW-1:0]             s1_status_ff;
   logic                      s1_done_ff;
   logic                      s1_hit_ff, s1_hit_in;

   // output register
   logic                      out_valid_ff;
   logic [OUT_W-1:0]          out_data_ff;
   logic [BW-1:0]             read_byte;

   // the output register frees the memory stage, the memory stage frees the input
   assign s1_move    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;
   assign feed_en    = accept && (action == atlf_pkg::ACT_FEED);
   assign read_en    = accept && (action == atlf_pkg::ACT_READ);

   atlf_parse #(
      .BANK_BYTES (BANK_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .feed_en   (feed_en),
      .byte_in   (byte_in),
      .wr        (wr),
      .wr_pos    (wr_pos),
      .clr_pos   (clr_pos),
      .status    (status),
      .done_bank (done_bank)
   );

   // bank b occupies entries b*BANK_BYTES and up
   assign wr_addr  = wr.bank ? (ADDR_W'(BANK_BYTES) + ADDR_W'(wr_pos)) : ADDR_W'(wr_pos);
   assign clr_addr = wr.bank ? (ADDR_W'(BANK_BYTES) + ADDR_W'(clr_pos)) : ADDR_W'(clr_pos);

   // reads go to the last completed bank, out-of-bank indexes read zero
   assign rd_in_bank = (32'(read_index) < 32'(BANK_BYTES));
   assign rd_pos     = rd_in_bank ? FILL_W'(read_index) : '0;
   assign rd_addr    = done_bank ? (ADDR_W'(BANK_BYTES) + ADDR_W'(rd_pos)) : ADDR_W'(rd_pos);
   assign s1_hit_in  = read_en && rd_in_bank && valid_ff[rd_addr];

   atlf_ram #(
      .WIDTH (BW),
      .DEPTH (DEPTH)
   ) u_bank_ram (
      .clock   (clock),
      .wr_en   (feed_en && wr.set),
      .wr_addr (wr_addr),
      .wr_data (byte_in),
      .rd_en   (read_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entry valid bits: unwritten or terminated entries read zero
   always_comb begin
      valid_in = valid_ff;
      if (feed_en) begin
         if (wr.clr) begin
            valid_in[clr_addr] = 1'b0;
         end
         if (wr.set) begin
            valid_in[wr_addr] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // memory stage, waits for the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= status;
         s1_done_ff   <= done_bank;
         s1_hit_ff    <= s1_hit_in;
      end
   end

   // ram output holds while the memory stage waits, no new read is issued
   assign read_byte = s1_hit_ff ? rd_data : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_valid_ff) begin
         out_data_ff <= {read_byte, s1_done_ff, s1_status_ff};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(16 - OUT_W)'(0), out_data_ff};

endmodule

`default_nettype wire

// ----- design/atlf_ram.sv -----
// ----------------------------------------------------------------------------
// atlf_ram: generic single write, single read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module atlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- design/atlf_parse.sv -----
// ----------------------------------------------------------------------------
// atlf_parse: line framing state machine
// tracks bank, fill position and response tail, issues bank writes
// ----------------------------------------------------------------------------
`default_nettype none

module atlf_parse #(
   parameter int BANK_BYTES = atlf_pkg::BANK_BYTES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              feed_en,
   input  wire logic [atlf_pkg::BYTE_W-1:0]       byte_in,
   output atlf_pkg::atlf_wr_type                  wr,
   output logic [$clog2(BANK_BYTES)-1:0]          wr_pos,
   output logic [$clog2(BANK_BYTES)-1:0]          clr_pos,
   output logic [atlf_pkg::STATUS_W-1:0]          status,
   output logic                                   done_bank
);

   localparam int FILL_W = $clog2(BANK_BYTES);
   localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BANK_BYTES - 1);

   logic                         active_ff, active_in;
   logic                         done_ff, done_in;
   logic [FILL_W-1:0]            fill_ff, fill_in;
   logic                         waiting_ff, waiting_in;
   logic                         resp_ff, resp_in;
   logic [atlf_pkg::TAIL_W-1:0]  tail_ff, tail_in;
   logic                         is_start;
   logic                         is_eol;
   logic                         room;

   assign is_start = byte_in inside {atlf_pkg::CH_A, atlf_pkg::CH_PLUS,
                                     atlf_pkg::CH_O, atlf_pkg::CH_E};
   assign is_eol   = byte_in inside {atlf_pkg::CH_CR, atlf_pkg::CH_LF};
   assign room     = (fill_ff < FILL_LAST);

   always_comb begin
      active_in  = active_ff;
      done_in    = done_ff;
      fill_in    = fill_ff;
      waiting_in = waiting_ff;
      resp_in    = resp_ff;
      tail_in    = tail_ff;
      wr         = '0;
      wr_pos     = fill_ff;
      clr_pos    = fill_ff;
      status     = atlf_pkg::STATUS_NONE;
      if (feed_en) begin
         if (waiting_ff) begin
            // every byte while idle flips the bank
            active_in = ~active_ff;
            fill_in   = '0;
            if (is_start) begin
               wr.set     = 1'b1;
               wr_pos     = '0;
               fill_in    = FILL_W'(1);
               waiting_in = 1'b0;
               resp_in    = (byte_in != atlf_pkg::CH_A);
               tail_in    = atlf_pkg::TAIL_W'(byte_in);
            end
         end else if (resp_ff) begin
            if (room) begin
               wr.set  = 1'b1;
               fill_in = fill_ff + FILL_W'(1);
               tail_in = {tail_ff[atlf_pkg::TAIL_W-atlf_pkg::BYTE_W-1:0], byte_in};
            end
            if (((fill_in >= FILL_W'(atlf_pkg::OK_MIN)) &&
                 (tail_in[atlf_pkg::OK_W-1:0] == atlf_pkg::TAIL_OK)) ||
                ((fill_in >= FILL_W'(atlf_pkg::ERROR_MIN)) &&
                 (tail_in == atlf_pkg::TAIL_ERROR))) begin
               wr.clr     = 1'b1;
               clr_pos    = fill_in;
               fill_in    = '0;
               waiting_in = 1'b1;
               resp_in    = 1'b0;
               done_in    = active_ff;
               status     = atlf_pkg::STATUS_RESP;
            end
         end else if (is_eol) begin
            wr.clr     = 1'b1;
            fill_in    = '0;
            waiting_in = 1'b1;
            done_in    = active_ff;
            status     = atlf_pkg::STATUS_CMD;
         end else if (room) begin
            wr.set  = 1'b1;
            fill_in = fill_ff + FILL_W'(1);
         end else begin
            // command overflow, dropped silently
            fill_in    = '0;
            waiting_in = 1'b1;
         end
      end
      wr.bank   = active_in;
      done_bank = done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         done_ff    <= 1'b0;
         fill_ff    <= '0;
         waiting_ff <= 1'b1;
         resp_ff    <= 1'b0;
         tail_ff    <= '0;
      end else begin
         active_ff  <= active_in;
         done_ff    <= done_in;
         fill_ff    <= fill_in;
         waiting_ff <= waiting_in;
         resp_ff    <= resp_in;
         tail_ff    <= tail_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/atlf_checker.sv -----
// ----------------------------------------------------------------------------
// atlf_checker: port level checks of the at line framer
// watches the result channel over time, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module atlf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item valid after reset");

   // a stalled result item stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   // status is one of the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == atlf_pkg::STATUS_NONE) ||
                     (rsp_tdata[1:0] == atlf_pkg::STATUS_CMD) ||
                     (rsp_tdata[1:0] == atlf_pkg::STATUS_RESP))
      else $error("undefined status code");

   // a completion comes from a feed, so it carries no read byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != atlf_pkg::STATUS_NONE) |-> rsp_tdata[10:3] == 8'd0)
      else $error("completion item carries a read byte");

   // padding above the fields stays zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:11] == 5'd0)
      else $error("result padding not zero");

endmodule

bind at_line_framer atlf_checker u_atlf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
